### hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pwfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the pulse width feature capture block
package pwfc_pkg;

    localparam int NUM_WIDTHS_DEF = 10;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 16;
    localparam int IDX_W      = 4;
    localparam int HIGH_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET = 12'd1500;
    localparam logic [VAL_W-1:0]      TIMEOUT_RESET   = 16'd5000;
    localparam logic [CFG_IDX_W-1:0]  CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_TIMEOUT     = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } t_div_status;

endpackage

### hdl/pwfc_cell.sv
`timescale 1ns / 1ps
// One stage of the width store chain
module pwfc_cell
    import pwfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [VAL_W-1:0] i_data,
    output logic [VAL_W-1:0] o_data
);

    logic [VAL_W-1:0] r_width;
    logic [VAL_W-1:0] n_width;

    always_comb begin
        n_width = i_shift ? i_data : r_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
        end else begin
            r_width <= n_width;
        end
    end

    assign o_data = r_width;

endmodule

### hdl/pwfc_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider for the Q0.16 duty fraction
module pwfc_div
    import pwfc_pkg::*;
#(
    parameter int TOT_W = VAL_W + 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HIGH_W-1:0] i_high,
    input  logic [TOT_W-1:0]  i_total,
    output t_div_status       o_status
);

    localparam int CW    = (HIGH_W > TOT_W) ? HIGH_W : TOT_W;
    localparam int REM_W = TOT_W + 1;
    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [REM_W-1:0] r_rem;
    logic [TOT_W-1:0] r_div;
    logic [VAL_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] rem_dbl;
    logic             ge;
    logic [REM_W-1:0] n_rem;

    always_comb begin
        rem_dbl = {r_rem[TOT_W-1:0], 1'b0};
        ge      = rem_dbl >= REM_W'(r_div);
        n_rem   = ge ? (rem_dbl - REM_W'(r_div)) : rem_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_div <= i_total;
            if (i_total == '0) begin
                r_quot <= '0;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (CW'(i_high) >= CW'(i_total)) begin
                r_quot <= '1;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_rem  <= REM_W'(i_high);
                r_quot <= '0;
                r_cnt  <= CNT_W'(VAL_W);
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[VAL_W-2:0], ge};
            r_cnt  <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.quot = r_quot;

endmodule

### hdl/pulse_width_feature_capture.sv
`timescale 1ns / 1ps
// Top level of the pulse width feature capture block.
// An item is accepted only in the idle state; an item that closes a run starts an
// emission of NUM_WIDTHS + 2 results, loaded into the output register in the emit
// state that follows the start state. The duty result waits on the 16-step divider,
// and no item is accepted during an emission. Synchronous active-low reset clears the
// width chain, the sums and the run state and presets the threshold and timeout.
module pulse_width_feature_capture
    import pwfc_pkg::*;
#(
    parameter int NUM_WIDTHS = NUM_WIDTHS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample_mv,
    input  logic [TIME_W-1:0]     i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_feature_index,
    output logic [VAL_W-1:0]      o_feature_value,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int FILL_W = $clog2(NUM_WIDTHS + 1);
    localparam int FEAT_W = $clog2(NUM_WIDTHS + 2);
    localparam int TOT_W  = VAL_W + $clog2(NUM_WIDTHS);

    t_state r_state;
    t_state n_state;

    logic [SAMPLE_W-1:0] r_threshold;
    logic [VAL_W-1:0]    r_timeout;

    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic                r_prior;
    logic                r_started;
    logic [TIME_W-1:0]   r_mark;
    logic [TIME_W-1:0]   n_mark;
    logic [HIGH_W-1:0]   r_high;
    logic [HIGH_W-1:0]   n_high;
    logic [TOT_W-1:0]    r_total;
    logic [TOT_W-1:0]    n_total;
    logic                r_emit_level;
    logic [FEAT_W-1:0]   r_feat;
    logic [FEAT_W-1:0]   n_feat;

    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_index;
    logic [VAL_W-1:0]    r_out_value;
    logic                r_out_last;

    logic                in_acc;
    logic                level;
    logic [TIME_W-1:0]   mark_eff;
    logic [TIME_W-1:0]   elapsed;
    logic                timed_out;
    logic                store_en;
    logic [VAL_W-1:0]    width_new;
    logic                high_bit;
    logic [HIGH_W:0]     high_sum;
    logic                emit;
    logic                div_start;
    logic                emit_on;
    logic                out_free;
    logic                feat_is_width;
    logic                feat_is_level;
    logic                feat_is_duty;
    logic                out_load;
    logic                chain_shift;
    logic [VAL_W-1:0]    chain_tail;
    logic [VAL_W-1:0]    feat_value;
    t_div_status         div_status;

    logic [VAL_W-1:0]    cell_q [NUM_WIDTHS];
    logic [VAL_W-1:0]    cell_d [NUM_WIDTHS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_timeout   <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // item evaluation
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        level     = i_sample_mv > r_threshold;
        mark_eff  = r_started ? r_mark : i_now_ms;
        elapsed   = i_now_ms - mark_eff;
        timed_out = elapsed >= TIME_W'(r_timeout);
        store_en  = in_acc && (timed_out || (level != r_prior));
        if (timed_out) begin
            width_new = r_timeout;
        end else if (elapsed[TIME_W-1:VAL_W] != '0) begin
            width_new = '1;
        end else begin
            width_new = elapsed[VAL_W-1:0];
        end
        high_bit = timed_out ? level : r_prior;
        high_sum = {1'b0, r_high} + (high_bit ? (HIGH_W + 1)'(width_new) : '0);
        emit     = in_acc && (timed_out ||
                   (store_en && (r_fill == FILL_W'(NUM_WIDTHS - 1))));
    end

    always_comb begin
        n_fill  = r_fill;
        n_mark  = r_mark;
        n_high  = r_high;
        n_total = r_total;
        if (div_start) begin
            n_high  = '0;
            n_total = '0;
        end
        if (in_acc) begin
            if (!r_started || store_en) begin
                n_mark = i_now_ms;
            end
            if (store_en) begin
                n_high  = high_sum[HIGH_W] ? '1 : high_sum[HIGH_W-1:0];
                n_total = r_total + TOT_W'(width_new);
                n_fill  = r_fill + FILL_W'(1);
            end
            if (emit) begin
                n_fill = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_prior   <= 1'b0;
            r_started <= 1'b0;
            r_mark    <= '0;
            r_high    <= '0;
            r_total   <= '0;
        end else begin
            r_fill  <= n_fill;
            r_mark  <= n_mark;
            r_high  <= n_high;
            r_total <= n_total;
            if (in_acc) begin
                r_prior   <= level;
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_emit_level <= r_prior;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (emit) n_state = S_START;
            S_START: n_state = S_EMIT;
            S_EMIT:  if (out_load && feat_is_duty) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        emit_on    = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_START: div_start  = 1'b1;
            S_EMIT:  emit_on    = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // emission
    always_comb begin
        out_free      = !r_out_valid || i_out_ready;
        feat_is_width = r_feat < FEAT_W'(NUM_WIDTHS);
        feat_is_level = r_feat == FEAT_W'(NUM_WIDTHS);
        feat_is_duty  = r_feat == FEAT_W'(NUM_WIDTHS + 1);
        out_load      = emit_on && out_free &&
                        (feat_is_width || feat_is_level || div_status.done);
        chain_shift   = store_en || (out_load && feat_is_width);
        chain_tail    = store_en ? width_new : '0;
        if (feat_is_width) begin
            feat_value = cell_q[0];
        end else if (feat_is_level) begin
            feat_value = VAL_W'(r_emit_level);
        end else begin
            feat_value = div_status.quot;
        end
        n_feat = r_feat;
        if (div_start) begin
            n_feat = '0;
        end else if (out_load) begin
            n_feat = r_feat + FEAT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_feat <= n_feat;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= IDX_W'(r_feat);
            r_out_value <= feat_value;
            r_out_last  <= feat_is_duty;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_feature_index = r_out_index;
    assign o_feature_value = r_out_value;
    assign o_last          = r_out_last;

    // width chain: new widths enter at the tail, emission drains from the head
    for (genvar g = 0; g < NUM_WIDTHS; g++) begin : g_cell
        if (g == NUM_WIDTHS - 1) begin : g_tail
            assign cell_d[g] = chain_tail;
        end else begin : g_link
            assign cell_d[g] = cell_q[g+1];
        end
        pwfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (chain_shift),
            .i_data  (cell_d[g]),
            .o_data  (cell_q[g])
        );
    end

    pwfc_div #(
        .TOT_W (TOT_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_high   (r_high),
        .i_total  (r_total),
        .o_status (div_status)
    );

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill < FILL_W'(NUM_WIDTHS), "fill past store depth")
    `ASSERT_NEXT(a_start_emit, i_clk, i_rst_n, r_state == S_START, r_state == S_EMIT, "start not followed by emit")
    `ASSERT_IMPL(a_emit_fill, i_clk, i_rst_n, r_state == S_EMIT, r_fill == '0, "fill not cleared during emit")

endmodule
